/* hdl/vfc_pkg.sv */
// Shared types and constants for the view frustum culling block.
// No dependencies; used by every module under hdl.
package vfc_pkg;

  localparam logic [2:0] KIND_LOAD   = 3'd0;
  localparam logic [2:0] KIND_POINT  = 3'd1;
  localparam logic [2:0] KIND_SPHERE = 3'd2;
  localparam logic [2:0] KIND_BOX    = 3'd3;
  localparam logic [2:0] KIND_CHUNK  = 3'd4;

  localparam logic [1:0] REG_CAM_X = 2'd0;
  localparam logic [1:0] REG_CAM_Y = 2'd1;
  localparam logic [1:0] REG_CAM_Z = 2'd2;
  localparam logic [1:0] REG_FAR   = 2'd3;

  localparam logic [30:0] FAR_LIMIT  = 31'd983040;
  localparam logic [30:0] FAR_MARGIN = 31'd131072;
  localparam logic [30:0] FAR_RESET  = 31'd983040;

  typedef struct packed {
    logic [2:0]         kind;
    logic [2:0]         plane_slot;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [31:0] scalar;
    logic signed [31:0] box_min_x;
    logic signed [31:0] box_min_y;
    logic signed [31:0] box_min_z;
    logic signed [31:0] box_max_x;
    logic signed [31:0] box_max_y;
    logic signed [31:0] box_max_z;
  } in_beat_t;

  typedef struct packed {
    logic        visible;
    logic [63:0] camera_dist_sq;
  } out_beat_t;

  typedef struct packed {
    logic signed [31:0] nx;
    logic signed [31:0] ny;
    logic signed [31:0] nz;
    logic signed [31:0] d;
  } plane_t;

  // Query handed from cell to cell: test point plus accumulated verdict
  typedef struct packed {
    logic               valid;
    logic               load;
    logic [2:0]         slot;
    logic               is_box;
    logic               vis;
    logic [63:0]        dsq;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] extra;
    logic signed [31:0] mnx;
    logic signed [31:0] mny;
    logic signed [31:0] mnz;
    logic signed [31:0] mxx;
    logic signed [31:0] mxy;
    logic signed [31:0] mxz;
  } query_t;

endpackage

/* hdl/vfc_cell.sv */
// One plane cell: holds one plane and tests the passing query against it.
// Depends on vfc_pkg.
module vfc_cell #(
  parameter int SLOT   = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            adv,
  input  vfc_pkg::query_t q_in,
  output vfc_pkg::query_t q_out
);
  import vfc_pkg::*;

  plane_t plane_r, plane_nxt;
  query_t q_r, q_nxt;
  // stage 1: products registered, stage register within the cell
  logic signed [63:0] px_r, py_r, pz_r, pd_r;
  query_t             q1_r;
  logic signed [31:0] vx, vy, vz;
  logic signed [66:0] sum;
  logic               below;

  // Pick the box vertex farthest along the plane normal, else the point itself
  always_comb begin
    vx = (q_in.is_box) ? ((plane_r.nx < 0) ? q_in.mnx : q_in.mxx) : q_in.px;
    vy = (q_in.is_box) ? ((plane_r.ny < 0) ? q_in.mny : q_in.mxy) : q_in.py;
    vz = (q_in.is_box) ? ((plane_r.nz < 0) ? q_in.mnz : q_in.mxz) : q_in.pz;
  end

  // Load plane when a load beat with this slot passes
  always_comb begin
    plane_nxt = plane_r;
    if (adv && q_in.valid && q_in.load && (int'(q_in.slot) == SLOT)) begin
      plane_nxt = '{nx: q_in.px, ny: q_in.py, nz: q_in.pz, d: q_in.extra};
    end
  end

  // Sum the signed distance and fold it into the verdict
  always_comb begin
    sum = 67'(px_r) + 67'(py_r) + 67'(pz_r) + 67'(pd_r);
    below = sum[66];
    q_nxt = q1_r;
    if (q1_r.valid && !q1_r.load && below) q_nxt.vis = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r  <= '0;
      q_r.valid  <= 1'b0;
      q1_r.valid <= 1'b0;
    end else begin
      plane_r <= plane_nxt;
      if (adv) begin
        q_r  <= q_nxt;
        q1_r <= q_in;
        px_r <= plane_r.nx * vx;
        py_r <= plane_r.ny * vy;
        pz_r <= plane_r.nz * vz;
        pd_r <= (64'(plane_r.d) <<< 16) + (q_in.is_box ? 64'sd0 : (64'(q_in.extra) <<< 16));
      end
    end
  end

  assign q_out = q_r;
endmodule

/* hdl/vfc_front.sv */
// Front stage: camera distance, box center, chunk range check.
// Depends on vfc_pkg.
module vfc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_take,
  input  vfc_pkg::in_beat_t beat,
  input  logic signed [31:0] cam_x,
  input  logic signed [31:0] cam_y,
  input  logic signed [31:0] cam_z,
  input  logic [30:0]       far_set,
  output vfc_pkg::query_t   q_out
);
  import vfc_pkg::*;

  logic signed [31:0] cx, cy, cz;
  logic [32:0]        ax, ay, az;
  logic [65:0]        sx_r, sy_r, sz_r;
  in_beat_t           b_r;
  logic               v_r;
  logic [66:0]        tot;
  logic [63:0]        dsq;
  logic [30:0]        far_c;
  logic [31:0]        eff;
  query_t             q_r, q_nxt;

  function automatic logic signed [31:0] mid32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    return s[32:1];
  endfunction

  function automatic logic [32:0] absd(input logic signed [31:0] a,
                                       input logic signed [31:0] b);
    logic signed [32:0] df;
    df = 33'(a) - 33'(b);
    return df[32] ? 33'(-df) : 33'(df);
  endfunction

  // Pick the center used for distance
  always_comb begin
    if (beat.kind == KIND_BOX) begin
      cx = mid32(beat.box_min_x, beat.box_max_x);
      cy = mid32(beat.box_min_y, beat.box_max_y);
      cz = mid32(beat.box_min_z, beat.box_max_z);
    end else begin
      cx = beat.vec_x;
      cy = beat.vec_y;
      cz = beat.vec_z;
    end
    ax = absd(cx, cam_x);
    ay = absd(cy, cam_y);
    az = absd(cz, cam_z);
  end

  // Saturate sum of squares and build the query
  always_comb begin
    tot   = 67'(sx_r) + 67'(sy_r) + 67'(sz_r);
    dsq   = (|tot[66:64]) ? '1 : tot[63:0];
    far_c = (far_set > FAR_LIMIT) ? FAR_LIMIT : far_set;
    eff   = 32'(far_c) + 32'(FAR_MARGIN);
    q_nxt = '0;
    q_nxt.valid  = v_r;
    q_nxt.load   = (b_r.kind == KIND_LOAD);
    q_nxt.slot   = b_r.plane_slot;
    q_nxt.is_box = (b_r.kind == KIND_BOX) || (b_r.kind == KIND_CHUNK);
    q_nxt.vis    = !((b_r.kind == KIND_CHUNK) && (dsq > 64'(eff) * 64'(eff)));
    q_nxt.dsq    = dsq;
    q_nxt.px     = b_r.vec_x;
    q_nxt.py     = b_r.vec_y;
    q_nxt.pz     = b_r.vec_z;
    q_nxt.extra  = (b_r.kind == KIND_POINT) ? 32'sd0 : b_r.scalar;
    q_nxt.mnx    = b_r.box_min_x;
    q_nxt.mny    = b_r.box_min_y;
    q_nxt.mnz    = b_r.box_min_z;
    q_nxt.mxx    = b_r.box_max_x;
    q_nxt.mxy    = b_r.box_max_y;
    q_nxt.mxz    = b_r.box_max_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r       <= 1'b0;
      q_r.valid <= 1'b0;
    end else if (adv) begin
      v_r  <= in_take && (beat.kind <= KIND_CHUNK);
      b_r  <= beat;
      sx_r <= ax * ax;
      sy_r <= ay * ay;
      sz_r <= az * az;
      q_r  <= q_nxt;
    end
  end

  assign q_out = q_r;
endmodule

/* hdl/view_frustum_culling.sv */
// View frustum culling: point, sphere, box and chunk tests against stored planes.
// Front registers squares, then query; each plane cell registers products, then verdict.
// Throughput: one beat per cycle; the whole cell chain stalls when the output holds.
// Synchronous active-low reset clears planes to zero, camera to 0, far to 15.0.
// Depends on vfc_pkg, vfc_front, vfc_cell.
module view_frustum_culling #(
  parameter int NUM_PLANES = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  vfc_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output vfc_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import vfc_pkg::*;

  logic signed [31:0] cam_x_r, cam_y_r, cam_z_r;
  logic [30:0]        far_r;
  logic               adv;
  query_t             chain [NUM_PLANES+1];
  query_t             tail;

  // Advance whole chain unless a finished result waits
  assign tail     = chain[NUM_PLANES];
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= '0;
      far_r   <= FAR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CAM_X: cam_x_r <= cfg_data;
        REG_CAM_Y: cam_y_r <= cfg_data;
        REG_CAM_Z: cam_z_r <= cfg_data;
        REG_FAR:   far_r   <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  vfc_front u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv), .in_take(in_valid),
    .beat(in_data), .cam_x(cam_x_r), .cam_y(cam_y_r), .cam_z(cam_z_r),
    .far_set(far_r), .q_out(chain[0])
  );

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_cell
    vfc_cell #(.SLOT(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .adv(adv), .q_in(chain[i]), .q_out(chain[i+1])
    );
  end

  // Drop load beats at the end of the chain
  assign out_valid               = tail.valid && !tail.load;
  assign out_data.visible        = tail.vis;
  assign out_data.camera_dist_sq = tail.dsq;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid && tail.load |-> !out_valid)
    else $error("load beat leaked to output");
endmodule
